// ----- design/cses_pkg.sv -----
package cses_pkg;

	localparam int ROWS        = 64;
	localparam int COLS        = 64;
	localparam int MAX_ENTRIES = 256;

	localparam int ROW_W = 6;
	localparam int COL_W = 6;
	localparam int VAL_W = 32;

	// entry address, entry count/pointer, row start table index, row sweep counter
	localparam int AW  = $clog2(MAX_ENTRIES);
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int RSW = $clog2(ROWS + 1);
	localparam int KW  = $clog2(ROWS + 2);

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic ST_DONE = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef struct packed {
		logic [COL_W-1:0]        col;
		logic signed [VAL_W-1:0] val;
	} entry_t;

endpackage

// ----- design/cses_if.sv -----
interface cses_req_if;
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic [cses_pkg::ROW_W-1:0]        row_index;
	logic [cses_pkg::COL_W-1:0]        col_index;
	logic signed [cses_pkg::VAL_W-1:0] write_value;

	modport source (output valid, output req_type, output row_index, output col_index,
		output write_value, input ready);
	modport sink (input valid, input req_type, input row_index, input col_index,
		input write_value, output ready);
endinterface

interface cses_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [cses_pkg::VAL_W-1:0] read_value;
	logic                              status;

	modport source (output valid, output read_value, output status, input ready);
	modport sink (input valid, input read_value, input status, output ready);
endinterface

// ----- design/csr_sparse_element_store.sv -----
// Sparse matrix element store in compressed-row form. Each request beat on req gives
// exactly one response beat on rsp. A read returns the element value or zero; a write
// overwrites, deletes (value zero) or appends at the end of the row; an append into a
// full entry store is refused with status 1. One request is handled at a time; how long it
// takes grows with the row entries searched, the entries moved and, only when an entry was
// added or removed, the later row starts adjusted. The entry memory and the row start memory
// each have a single read port and are walked one entry per cycle.
// A finished response waits in an output register, so a new request may be taken then.
module csr_sparse_element_store (
	input logic   clk,
	input logic   arst_n,
	cses_req_if.sink   req,
	cses_rsp_if.source rsp
);
	import cses_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LO   = 4'd1;
	localparam logic [3:0] S_HI   = 4'd2;
	localparam logic [3:0] S_BND  = 4'd3;
	localparam logic [3:0] S_SRCH = 4'd4;
	localparam logic [3:0] S_ACT  = 4'd5;
	localparam logic [3:0] S_SHF  = 4'd6;
	localparam logic [3:0] S_PUT  = 4'd7;
	localparam logic [3:0] S_ADJ  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0] state_q;

	// memories
	entry_t        ent_mem [MAX_ENTRIES];
	logic [CW-1:0] rs_mem  [ROWS+1];
	logic [ROWS:0] rs_vld_q;

	entry_t        ent_rd_q;
	logic [CW-1:0] rs_rd_q;
	logic          rs_rdv_q;
	logic [CW-1:0] rs_data;

	logic [AW-1:0]  ent_raddr;
	logic           ent_we;
	logic [AW-1:0]  ent_waddr;
	entry_t         ent_wdata;
	logic [RSW-1:0] rs_raddr;
	logic           rs_we;
	logic [CW-1:0]  rs_wdata;

	// request
	logic                    req_type_q;
	logic [ROW_W-1:0]        row_q;
	logic [COL_W-1:0]        col_q;
	logic signed [VAL_W-1:0] wval_q;

	// sequencer
	logic [CW-1:0]  total_q;
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  hi_q;
	logic [CW-1:0]  pos_q;
	logic [CW-1:0]  ra_q;
	logic [AW-1:0]  wa_q;
	logic [CW-1:0]  cnt_q;
	logic           dir_q;
	logic           pend_q;
	logic           found_q;
	logic [KW-1:0]  k_q;
	logic [RSW-1:0] kw_q;

	logic signed [VAL_W-1:0] fval_q;
	logic signed [VAL_W-1:0] rd_q;
	logic                    st_q;

	logic                    rsp_valid_q;
	logic signed [VAL_W-1:0] rsp_value_q;
	logic                    rsp_status_q;

	logic accept;
	logic out_free;
	logic in_range;
	logic vzero;
	logic hit;

	assign req.ready    = (state_q == S_IDLE);
	assign accept       = req.valid && req.ready;
	assign out_free     = !rsp_valid_q || rsp.ready;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.status   = rsp_status_q;

	assign in_range = (32'(req.row_index) < ROWS) && (32'(req.col_index) < COLS);
	assign vzero    = (wval_q == '0);
	assign hit      = pend_q && (ent_rd_q.col == col_q);
	// never-written row starts read as zero
	assign rs_data  = rs_rdv_q ? rs_rd_q : '0;

	// memory port control
	always_comb begin
		ent_raddr = idx_q[AW-1:0];
		ent_we    = 1'b0;
		ent_waddr = pos_q[AW-1:0];
		ent_wdata = '{col: col_q, val: wval_q};
		rs_raddr  = '0;
		rs_we     = 1'b0;
		rs_wdata  = rs_data;
		unique case (state_q)
			S_LO:  rs_raddr = RSW'(row_q);
			S_HI:  rs_raddr = RSW'(row_q) + RSW'(1);
			S_ACT: ent_we   = (req_type_q == REQ_WRITE) && found_q && !vzero;
			S_SHF: begin
				ent_raddr = ra_q[AW-1:0];
				ent_we    = pend_q;
				ent_waddr = wa_q;
				ent_wdata = ent_rd_q;
			end
			S_PUT: begin
				ent_we    = 1'b1;
				ent_waddr = hi_q[AW-1:0];
			end
			S_ADJ: begin
				if (k_q <= KW'(ROWS)) begin
					rs_raddr = k_q[RSW-1:0];
				end
				rs_we = pend_q;
				if (dir_q) begin
					rs_wdata = rs_data + CW'(1);
				end else if (rs_data != '0) begin
					rs_wdata = rs_data - CW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		ent_rd_q <= ent_mem[ent_raddr];
		if (rs_we) begin
			rs_mem[kw_q] <= rs_wdata;
		end
		rs_rd_q  <= rs_mem[rs_raddr];
		rs_rdv_q <= rs_vld_q[rs_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_vld_q <= '0;
		end else if (rs_we) begin
			rs_vld_q[kw_q] <= 1'b1;
		end
	end

	// request payload and result data
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			row_q      <= req.row_index;
			col_q      <= req.col_index;
			wval_q     <= req.write_value;
			rd_q       <= '0;
			st_q       <= ST_DONE;
		end
		if (state_q == S_SRCH && hit) begin
			fval_q <= ent_rd_q.val;
		end
		if (state_q == S_ACT) begin
			if (req_type_q == REQ_READ) begin
				rd_q <= found_q ? fval_q : '0;
			end else if (!found_q && !vzero && total_q == CW'(MAX_ENTRIES)) begin
				st_q <= ST_FULL;
			end
		end
		if (state_q == S_OUT && out_free) begin
			rsp_value_q  <= rd_q;
			rsp_status_q <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			idx_q       <= '0;
			hi_q        <= '0;
			pos_q       <= '0;
			ra_q        <= '0;
			wa_q        <= '0;
			cnt_q       <= '0;
			dir_q       <= 1'b0;
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			k_q         <= '0;
			kw_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= in_range ? S_LO : S_OUT;
					end
				end
				S_LO: state_q <= S_HI;
				S_HI: begin
					idx_q   <= rs_data;
					state_q <= S_BND;
				end
				S_BND: begin
					hi_q    <= rs_data;
					pend_q  <= 1'b0;
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					// compare of the entry read last cycle overlaps the next read
					if (hit) begin
						found_q <= 1'b1;
						pos_q   <= idx_q - CW'(1);
						pend_q  <= 1'b0;
						state_q <= S_ACT;
					end else if (idx_q < hi_q) begin
						idx_q  <= idx_q + CW'(1);
						pend_q <= 1'b1;
					end else begin
						found_q <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					pend_q  <= 1'b0;
					state_q <= S_OUT;
					if (req_type_q == REQ_WRITE) begin
						if (found_q && vzero) begin
							// delete: pull later entries down one place
							dir_q   <= 1'b0;
							ra_q    <= pos_q + CW'(1);
							cnt_q   <= total_q - pos_q - CW'(1);
							total_q <= total_q - CW'(1);
							state_q <= S_SHF;
						end else if (!found_q && !vzero && total_q != CW'(MAX_ENTRIES)) begin
							// append at row end: push later entries up, top first
							dir_q   <= 1'b1;
							ra_q    <= total_q - CW'(1);
							cnt_q   <= total_q - hi_q;
							total_q <= total_q + CW'(1);
							state_q <= S_SHF;
						end
					end
				end
				S_SHF: begin
					if (cnt_q != '0) begin
						ra_q   <= dir_q ? ra_q - CW'(1) : ra_q + CW'(1);
						wa_q   <= dir_q ? ra_q[AW-1:0] + AW'(1) : ra_q[AW-1:0] - AW'(1);
						cnt_q  <= cnt_q - CW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							k_q     <= KW'(row_q) + KW'(1);
							state_q <= dir_q ? S_PUT : S_ADJ;
						end
					end
				end
				S_PUT: state_q <= S_ADJ;
				S_ADJ: begin
					// read-modify-write sweep over the later row starts
					if (k_q <= KW'(ROWS)) begin
						kw_q   <= k_q[RSW-1:0];
						k_q    <= k_q + KW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- dv/testbench.sv -----
module testbench;
	import cses_pkg::*;

	typedef struct {
		logic                    req_type;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
		bit                      wait_idle;
	} elem_req_t;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    status;
	} elem_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	cses_req_if req_ch ();
	cses_rsp_if rsp_ch ();

	csr_sparse_element_store i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// shadow copy of the compressed-row store
	int unsigned      row_base [0:ROWS];
	logic [COL_W-1:0] ent_col  [0:MAX_ENTRIES-1];
	logic [VAL_W-1:0] ent_val  [0:MAX_ENTRIES-1];

	elem_req_t   pending_reqs [$];
	elem_rsp_t   expected_rsp [$];
	elem_req_t   on_bus;
	logic [11:0] known_pos [$];

	int n_sent;
	int n_errors;
	int hold_left;
	bit hold_done;
	logic quiet;

	assign quiet = (n_sent >= 1000) && (n_sent < 1350);

	function automatic elem_rsp_t access_element(input elem_req_t it);
		elem_rsp_t res;
		int unsigned r;
		int unsigned c;
		int unsigned lo;
		int unsigned hi;
		int unsigned total;
		int unsigned p;
		int unsigned i;
		int unsigned k;
		int pos;
		res.value  = '0;
		res.status = ST_DONE;
		r = 32'(it.row);
		c = 32'(it.col);
		if (r < ROWS && c < COLS) begin
			lo = row_base[r];
			hi = row_base[r + 1];
			if (hi > MAX_ENTRIES) hi = MAX_ENTRIES;
			pos = -1;
			for (i = lo; i < hi; i++)
				if (pos < 0 && ent_col[i] == c) pos = int'(i);
			total = row_base[ROWS];
			if (total > MAX_ENTRIES) total = MAX_ENTRIES;

			if (it.req_type == REQ_READ) begin
				if (pos >= 0) res.value = ent_val[pos];
			end else if (pos >= 0) begin
				if (it.value != 0) begin
					ent_val[pos] = it.value;
				end else begin
					// delete: close the gap and pull later row starts down
					for (i = unsigned'(pos); i + 1 < total; i++) begin
						ent_col[i] = ent_col[i + 1];
						ent_val[i] = ent_val[i + 1];
					end
					for (k = r + 1; k <= ROWS; k++)
						if (row_base[k] > 0) row_base[k] = row_base[k] - 1;
				end
			end else if (it.value != 0) begin
				if (total >= MAX_ENTRIES) begin
					res.status = ST_FULL;
				end else begin
					// append at the end of the row
					p = row_base[r + 1];
					if (p > total) p = total;
					for (i = total; i > p; i--) begin
						ent_col[i] = ent_col[i - 1];
						ent_val[i] = ent_val[i - 1];
					end
					ent_col[p] = COL_W'(c);
					ent_val[p] = it.value;
					for (k = r + 1; k <= ROWS; k++)
						row_base[k] = row_base[k] + 1;
				end
			end
		end
		return res;
	endfunction

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		n_errors++;
		$display("%0t: %s: expected %h got %h", $time, what, want, got);
	endtask

	function automatic elem_req_t mk_req(input logic t, input int r, input int c,
		input logic [31:0] v);
		elem_req_t it;
		it.req_type  = t;
		it.row       = ROW_W'(r);
		it.col       = COL_W'(c);
		it.value     = v;
		it.wait_idle = 1'b0;
		return it;
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(7))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2: v = 32'hffff_ffff;
			3: v = 32'h0000_0001;
			default: v = $urandom;
		endcase
		if (v == 0) v = 32'h0001_0000;
		return v;
	endfunction

	// low rows get crowded so that searches and shifts run long
	function automatic logic [11:0] fresh_pos();
		logic [5:0] r;
		logic [5:0] c;
		r = ($urandom_range(99) < 40) ? 6'($urandom_range(3)) : 6'($urandom_range(63));
		c = 6'($urandom_range(63));
		return {r, c};
	endfunction

	task automatic add_random(input int n, input int pct_new, input int pct_read,
		input int pct_over);
		int j;
		int roll;
		int idx;
		logic [11:0] pos;
		elem_req_t it;
		for (j = 0; j < n; j++) begin
			roll = $urandom_range(99);
			if (roll < pct_new || known_pos.size() == 0) begin
				pos = fresh_pos();
				it = mk_req(REQ_WRITE, int'(pos[11:6]), int'(pos[5:0]), pick_value());
				known_pos.push_back(pos);
			end else if (roll < pct_new + pct_read) begin
				pos = ($urandom_range(1) == 0) ? fresh_pos()
					: known_pos[$urandom_range(known_pos.size() - 1)];
				it = mk_req(REQ_READ, int'(pos[11:6]), int'(pos[5:0]), $urandom);
			end else if (roll < pct_new + pct_read + pct_over) begin
				pos = known_pos[$urandom_range(known_pos.size() - 1)];
				it = mk_req(REQ_WRITE, int'(pos[11:6]), int'(pos[5:0]), pick_value());
			end else if ($urandom_range(9) == 0) begin
				// zero to a most likely absent element
				pos = fresh_pos();
				it = mk_req(REQ_WRITE, int'(pos[11:6]), int'(pos[5:0]), 32'h0);
			end else begin
				idx = $urandom_range(known_pos.size() - 1);
				pos = known_pos[idx];
				known_pos.delete(idx);
				it = mk_req(REQ_WRITE, int'(pos[11:6]), int'(pos[5:0]), 32'h0);
			end
			if (j == 0) it.wait_idle = 1'b1;
			pending_reqs.push_back(it);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.req_type    <= REQ_READ;
			req_ch.row_index   <= '0;
			req_ch.col_index   <= '0;
			req_ch.write_value <= '0;
			n_sent             <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_rsp.push_back(access_element(on_bus));
				n_sent <= n_sent + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0
					&& !(pending_reqs[0].wait_idle && expected_rsp.size() != 0)
					&& (quiet || $urandom_range(99) >= 25)) begin
					on_bus = pending_reqs.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.req_type    <= on_bus.req_type;
					req_ch.row_index   <= on_bus.row;
					req_ch.col_index   <= on_bus.col;
					req_ch.write_value <= on_bus.value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// one long receiver stall, early enough to back up the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_sent >= 700) begin
			hold_left <= 3000;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		elem_rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsp.size() == 0) begin
					report("unexpected beat", 32'h0, rsp_ch.read_value);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp_ch.read_value !== want.value)
						report("read_value", want.value, rsp_ch.read_value);
					if (rsp_ch.status !== want.status)
						report("status", 32'(want.status), 32'(rsp_ch.status));
				end
			end
			rsp_ch.ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 25);
		end
	end

	initial begin
		int k;
		n_errors = 0;
		for (k = 0; k <= ROWS; k++) row_base[k] = 0;

		// directed: empty reads, row and column extremes, value extremes,
		// overwrite, delete with shifts, zero to an absent element
		pending_reqs.push_back(mk_req(REQ_READ,   0,  0, 32'hffff_ffff));
		pending_reqs.push_back(mk_req(REQ_WRITE,  0,  0, 32'h7fff_ffff));
		pending_reqs.push_back(mk_req(REQ_WRITE, 63, 63, 32'h8000_0000));
		pending_reqs.push_back(mk_req(REQ_WRITE,  0, 63, 32'h0000_0001));
		pending_reqs.push_back(mk_req(REQ_READ,   0,  0, 32'h0));
		pending_reqs.push_back(mk_req(REQ_READ,   0, 63, 32'h0));
		pending_reqs.push_back(mk_req(REQ_READ,  63, 63, 32'h0));
		pending_reqs.push_back(mk_req(REQ_READ,  63,  0, 32'h1234_5678));
		pending_reqs.push_back(mk_req(REQ_WRITE,  0,  0, 32'hffff_ffff));
		pending_reqs.push_back(mk_req(REQ_READ,   0,  0, 32'h0));
		pending_reqs.push_back(mk_req(REQ_WRITE,  0,  0, 32'h0));
		pending_reqs.push_back(mk_req(REQ_READ,   0,  0, 32'h0));
		pending_reqs.push_back(mk_req(REQ_READ,   0, 63, 32'h0));
		pending_reqs.push_back(mk_req(REQ_WRITE,  5,  7, 32'h0));
		pending_reqs.push_back(mk_req(REQ_READ,   5,  7, 32'h0));
		pending_reqs.push_back(mk_req(REQ_WRITE, 32, 32, 32'h0001_0000));
		pending_reqs.push_back(mk_req(REQ_WRITE, 32, 31, 32'hfffe_8000));
		pending_reqs.push_back(mk_req(REQ_READ,  63, 63, 32'h0));
		pending_reqs.push_back(mk_req(REQ_WRITE,  0, 63, 32'h0));
		pending_reqs.push_back(mk_req(REQ_WRITE, 63, 63, 32'h0));
		pending_reqs.push_back(mk_req(REQ_READ,  63, 63, 32'h0));
		pending_reqs.push_back(mk_req(REQ_READ,  32, 32, 32'h0));
		pending_reqs.push_back(mk_req(REQ_READ,  32, 31, 32'h0));

		// rounds of fill to full, churn at full, then drain
		for (k = 0; k < 3; k++) begin
			add_random(380, 80, 10, 5);
			add_random(140, 30, 30, 20);
			add_random(160,  0, 25,  0);
		end

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_ch.valid) @(posedge clk);
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (n_errors == 0)
			$display("csr_sparse_element_store: match");
		else
			$display("csr_sparse_element_store: mismatch");
		$finish;
	end

	initial begin
		#40000000;
		$display("csr_sparse_element_store: mismatch");
		$finish;
	end

endmodule
